### rtl/gda_pkg.sv
// ============================================================================
// gda_pkg: shared types and calendar helpers
// Day-number helpers for the Gregorian date unit. Divisions by constants are
// reciprocal multiplies, exact over the year range the block can see.
// ============================================================================
package gda_pkg;

  // Day number of 10000-01-01: first day past the legal range
  localparam logic [22:0] YS_END = 23'd3652425;
  // ceil(400 * 2^30 / 146097): day number to year estimate
  localparam logic [21:0] RECIP_K = 22'd2939806;
  localparam int RECIP_SH = 30;

  typedef struct packed {
    logic        func;
    logic [13:0] year_a;
    logic [3:0]  month_a;
    logic [4:0]  day_a;
    logic [13:0] year_b;
    logic [3:0]  month_b;
    logic [4:0]  day_b;
    logic signed [23:0] offset;
  } item_t;

  typedef struct packed {
    logic func;
    logic less;
    logic equal;
    logic valid;
    logic rerr;
  } flags_t;

  // floor(x / 100), exact for x < 25600
  function automatic logic [7:0] div100(input logic [14:0] x);
    logic [27:0] p;
    p = 28'(x) * 28'd5243;
    return p[26:19];
  endfunction

  // 4/100/400 rule, year 0 is leap
  function automatic logic is_leap(input logic [13:0] y);
    logic [7:0] q;
    logic       z;
    q = div100({1'b0, y});
    z = ({1'b0, y} == 15'(q) * 15'd100);
    return (y[1:0] == 2'b00 && !z) || (z && q[1:0] == 2'b00);
  endfunction

  // days from 0000-01-01 to Jan 1 of year y
  function automatic logic [22:0] year_start(input logic [13:0] y);
    logic [14:0] y15;
    y15 = {1'b0, y};
    return 23'(y) * 23'd365 + 23'((y15 + 15'd3) >> 2)
           - 23'(div100(y15 + 15'd99)) + 23'(div100(y15 + 15'd399) >> 2);
  endfunction

  // days before the first of month m (common year)
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     r = 5'd30;
      4'd2:    r = leap ? 5'd29 : 5'd28;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/gda_if.sv
// ============================================================================
// gda_if: item and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ============================================================================
interface gda_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [13:0]        year_a;
  logic [3:0]         month_a;
  logic [4:0]         day_a;
  logic [13:0]        year_b;
  logic [3:0]         month_b;
  logic [4:0]         day_b;
  logic signed [23:0] offset;

  modport source (output valid, func, year_a, month_a, day_a, year_b, month_b, day_b,
                  offset, input ready);
  modport sink (input valid, func, year_a, month_a, day_a, year_b, month_b, day_b,
                offset, output ready);
endinterface

interface gda_out_if;
  logic               valid;
  logic               ready;
  logic [13:0]        res_year;
  logic [3:0]         res_month;
  logic [4:0]         res_day;
  logic signed [23:0] difference;
  logic               a_less;
  logic               a_equal;
  logic               a_valid;
  logic               range_error;

  modport source (output valid, res_year, res_month, res_day, difference, a_less,
                  a_equal, a_valid, range_error, input ready);
  modport sink (input valid, res_year, res_month, res_day, difference, a_less,
                a_equal, a_valid, range_error, output ready);
endinterface

### rtl/gregorian_date_arithmetic.sv
// ============================================================================
// gregorian_date_arithmetic: Gregorian date shift and difference unit
// Converts dates to day numbers from 0000-01-01, adds an offset or takes a
// difference, and converts back to year, month and day.
// ============================================================================
// An eight-stage pipeline that takes one item per clock. All stages advance
// together: when the output register holds a beat that is not taken, the
// whole pipeline holds and ready drops, so nothing is lost or repeated.
// Stages: input capture, year-start and leap terms for A and B, day numbers,
// shifted day number with range check and difference, year estimate (22x22
// constant multiply), candidate year starts, year pick with day of year, then
// month/day and the output register. Func 0 fills res_year/res_month/res_day
// (zero on a range error) and leaves difference zero; func 1 fills difference
// only. The compare and validity flags are given for both.
module gregorian_date_arithmetic import gda_pkg::*; (
  input logic clk,
  input logic rst,
  gda_in_if.sink    item,
  gda_out_if.source result
);

  logic       en;
  logic [8:1] v;

  item_t       p1;
  // stage 2
  item_t       p2;
  logic [22:0] ys_a2, ys_b2;
  logic        leap_a2, leap_b2;
  // stage 3
  flags_t             fl3;
  logic signed [24:0] na3, nb3;
  logic signed [23:0] off3;
  // stage 4
  flags_t             fl4;
  logic signed [25:0] s4;
  logic [23:0]        diff4;
  // stages 5..7 sideband while the date converter works
  flags_t             fl_p   [5:7];
  logic [23:0]        diff_p [5:7];

  logic [3:0]         mc_a, mc_b;
  logic signed [25:0] s_next;
  logic [13:0]        cv_year;
  logic [3:0]         cv_month;
  logic [4:0]         cv_day;

  // output register
  logic [13:0]        res_year;
  logic [3:0]         res_month;
  logic [4:0]         res_day;
  logic [23:0]        difference;
  flags_t             fl8;

  assign en         = !v[8] || result.ready;
  assign item.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[7:1], item.valid};
    end
  end

  // stage 1: capture beat
  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= '{func: item.func, year_a: item.year_a, month_a: item.month_a,
              day_a: item.day_a, year_b: item.year_b, month_b: item.month_b,
              day_b: item.day_b, offset: item.offset};
    end
  end

  // stage 2: year starts and leap flags
  always_ff @(posedge clk) begin
    if (en) begin
      p2      <= p1;
      ys_a2   <= year_start(p1.year_a);
      ys_b2   <= year_start(p1.year_b);
      leap_a2 <= is_leap(p1.year_a);
      leap_b2 <= is_leap(p1.year_b);
    end
  end

  // out-of-range months clamp to January / December for the day number
  assign mc_a = (p2.month_a == 4'd0) ? 4'd1 : (p2.month_a > 4'd12) ? 4'd12 : p2.month_a;
  assign mc_b = (p2.month_b == 4'd0) ? 4'd1 : (p2.month_b > 4'd12) ? 4'd12 : p2.month_b;

  // stage 3: day numbers and flags (compares on raw fields)
  always_ff @(posedge clk) begin
    if (en) begin
      na3 <= 25'(ys_a2) + 25'(days_before(mc_a)) + 25'((mc_a > 4'd2) && leap_a2)
             + 25'(p2.day_a) - 25'sd1;
      nb3 <= 25'(ys_b2) + 25'(days_before(mc_b)) + 25'((mc_b > 4'd2) && leap_b2)
             + 25'(p2.day_b) - 25'sd1;
      off3 <= p2.offset;
      fl3.func  <= p2.func;
      fl3.less  <= (p2.year_a < p2.year_b)
                || (p2.year_a == p2.year_b && p2.month_a < p2.month_b)
                || (p2.year_a == p2.year_b && p2.month_a == p2.month_b
                    && p2.day_a < p2.day_b);
      fl3.equal <= (p2.year_a == p2.year_b) && (p2.month_a == p2.month_b)
                && (p2.day_a == p2.day_b);
      fl3.valid <= (p2.month_a >= 4'd1) && (p2.month_a <= 4'd12) && (p2.day_a >= 5'd1)
                && (p2.day_a <= month_len(p2.month_a, leap_a2));
      fl3.rerr  <= 1'b0;
    end
  end

  // stage 4: shifted day number, range check, difference
  assign s_next = 26'(na3) + 26'(off3);

  always_ff @(posedge clk) begin
    if (en) begin
      s4    <= s_next;
      diff4 <= 24'(na3 - nb3);
      fl4   <= '{func: fl3.func, less: fl3.less, equal: fl3.equal, valid: fl3.valid,
                 rerr: !fl3.func
                       && (s_next < 26'sd0 || s_next >= $signed(26'(YS_END)))};
    end
  end

  gda_civil u_civil (
    .clk   (clk),
    .en    (en),
    .s     (s4[21:0]),
    .year  (cv_year),
    .month (cv_month),
    .day   (cv_day)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      fl_p[5]   <= fl4;
      diff_p[5] <= diff4;
      for (int k = 6; k <= 7; k++) begin
        fl_p[k]   <= fl_p[k-1];
        diff_p[k] <= diff_p[k-1];
      end
    end
  end

  // stage 8: output register
  always_ff @(posedge clk) begin
    if (en) begin
      fl8 <= fl_p[7];
      if (!fl_p[7].func && !fl_p[7].rerr) begin
        res_year  <= cv_year;
        res_month <= cv_month;
        res_day   <= cv_day;
      end else begin
        res_year  <= '0;
        res_month <= '0;
        res_day   <= '0;
      end
      difference <= fl_p[7].func ? diff_p[7] : '0;
    end
  end

  assign result.valid       = v[8];
  assign result.res_year    = res_year;
  assign result.res_month   = res_month;
  assign result.res_day     = res_day;
  assign result.difference  = difference;
  assign result.a_less      = fl8.less;
  assign result.a_equal     = fl8.equal;
  assign result.a_valid     = fl8.valid;
  assign result.range_error = fl8.rerr;

endmodule

### rtl/gda_civil.sv
// ============================================================================
// gda_civil: day number to calendar date
// Three register stages: year estimate, candidate year starts, year pick.
// Month and day come out combinationally from the last stage.
// ============================================================================
module gda_civil import gda_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [21:0] s,
  output logic [13:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day
);

  // stage A: estimate product
  logic [43:0] prod;
  logic [21:0] s_a;

  // stage B: four candidate years around the estimate
  logic [13:0] cand [4];
  logic [22:0] ysc  [4];
  logic        lc   [4];
  logic        cok  [4];
  logic [21:0] s_b;

  // stage C: chosen year
  logic [13:0] y_c;
  logic [8:0]  doy;
  logic        leap_c;

  logic [13:0] est;
  logic [15:0] c_next [4];
  logic [1:0]  sel;
  logic [3:0]  m;
  logic [8:0]  adj_m;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= 44'(s) * 44'(RECIP_K);
      s_a  <= s;
    end
  end

  assign est = prod[RECIP_SH +: 14];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      c_next[k] = {2'b00, est} + 16'(k) - 16'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        cand[k] <= c_next[k][13:0];
        ysc[k]  <= year_start(c_next[k][13:0]);
        lc[k]   <= is_leap(c_next[k][13:0]);
        cok[k]  <= !c_next[k][15];
      end
      s_b <= s_a;
    end
  end

  // largest candidate whose year start is not past s
  always_comb begin
    sel = 2'd0;
    for (int k = 0; k < 4; k++) begin
      if (cok[k] && ysc[k] <= 23'(s_b)) begin
        sel = 2'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_c    <= cand[sel];
      doy    <= 9'(23'(s_b) - ysc[sel]);
      leap_c <= lc[sel];
    end
  end

  always_comb begin
    m = 4'd1;
    for (int k = 2; k <= 12; k++) begin
      if (doy >= days_before(4'(k)) + 9'((k > 2) && leap_c)) begin
        m = m + 4'd1;
      end
    end
    adj_m = 9'((m > 4'd2) && leap_c);
  end

  assign year  = y_c;
  assign month = m;
  assign day   = 5'(doy - days_before(m) - adj_m + 9'd1);

endmodule

### sim/gda_tb_if.sv
// ============================================================================
// gda_tb_if: testbench notes on the item and result channels
// The channel interfaces come with the RTL (rtl/gda_if.sv); this file holds
// the beat record the testbench keeps per expected result and the func codes.
// ============================================================================
package gda_tb_pkg;

  typedef struct packed {
    logic [13:0]        res_year;
    logic [3:0]         res_month;
    logic [4:0]         res_day;
    logic signed [23:0] difference;
    logic               a_less;
    logic               a_equal;
    logic               a_valid;
    logic               range_error;
  } date_result_t;

  localparam logic FUNC_SHIFT = 1'b0;
  localparam logic FUNC_DIFF  = 1'b1;

endpackage

### sim/tb.sv
// ============================================================================
// tb: testbench for gregorian_date_arithmetic
// Drives date items through the valid/ready input channel, predicts each
// result from a calendar model kept here, and checks every result beat in
// order. A directed table runs first, then about 600 random items.
// ============================================================================
module tb;
  import gda_pkg::*;
  import gda_tb_pkg::*;

  localparam int IDLE_LIMIT = 5000;  // cycles with no beat before giving up
  localparam int DRAIN_CYCLES = 20;  // pipeline is eight deep
  localparam int RANDOM_ITEMS = 600;

  logic clk;
  logic rst;
  gda_in_if  item ();
  gda_out_if result ();

  gregorian_date_arithmetic uut (
    .clk(clk), .rst(rst), .item(item.sink), .result(result.source)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Calendar model
  // ---------------------------------------------------------------------------
  function automatic bit leap(longint y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic longint mlen(longint y, longint m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic longint jan1(longint y);
    return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
  endfunction

  // out-of-range months clamp; the day runs linearly from the first
  function automatic longint day_count(longint y, longint m, longint d);
    longint n;
    longint mm;
    mm = (m < 1) ? 1 : (m > 12) ? 12 : m;
    n = jan1(y);
    for (longint k = 1; k < mm; k++) n += mlen(y, k);
    return n + d - 1;
  endfunction

  function automatic date_result_t predict_date(item_t it);
    date_result_t r;
    longint na, s, y, m, doy;
    r = '0;
    na = day_count(it.year_a, it.month_a, it.day_a);
    r.a_less = (it.year_a < it.year_b) ||
               (it.year_a == it.year_b && it.month_a < it.month_b) ||
               (it.year_a == it.year_b && it.month_a == it.month_b &&
                it.day_a < it.day_b);
    r.a_equal = (it.year_a == it.year_b) && (it.month_a == it.month_b) &&
                (it.day_a == it.day_b);
    r.a_valid = it.month_a >= 1 && it.month_a <= 12 && it.day_a >= 1 &&
                it.day_a <= mlen(it.year_a, it.month_a);
    if (it.func == FUNC_SHIFT) begin
      s = na + longint'(it.offset);
      if (s < 0 || s >= jan1(10000)) begin
        r.range_error = 1'b1;
      end else begin
        y = (s * 400) / 146097;
        while (y > 0 && jan1(y) > s) y--;
        while (jan1(y + 1) <= s) y++;
        doy = s - jan1(y);
        m = 1;
        while (m < 12 && doy >= mlen(y, m)) begin
          doy -= mlen(y, m);
          m++;
        end
        r.res_year = 14'(y);
        r.res_month = 4'(m);
        r.res_day = 5'(doy + 1);
      end
    end else begin
      r.difference = 24'(na - day_count(it.year_b, it.month_b, it.day_b));
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table; has_exp rows carry a hand-read result
  // ---------------------------------------------------------------------------
  typedef struct {
    item_t        it;
    bit           has_exp;
    date_result_t exp;
  } row_t;

  row_t table_rows[$];
  date_result_t expected_dates[$];
  int  failures;
  int  accepted_items;
  int  checked_results;
  int  shift_count, diff_count, rerr_count, invalid_count;
  bit  stimulus_done;
  bit  hold_off;  // long receiver stall, set by its own process

  function automatic item_t mk(logic f, int ya, int ma, int da, int yb, int mb,
                               int db, int off);
    item_t it;
    it.func = f;
    it.year_a = 14'(ya); it.month_a = 4'(ma); it.day_a = 5'(da);
    it.year_b = 14'(yb); it.month_b = 4'(mb); it.day_b = 5'(db);
    it.offset = 24'(off);
    return it;
  endfunction

  function automatic date_result_t mkr(int y, int m, int d, int df, bit l, bit e,
                                       bit v, bit re);
    date_result_t r;
    r.res_year = 14'(y); r.res_month = 4'(m); r.res_day = 5'(d);
    r.difference = 24'(df);
    r.a_less = l; r.a_equal = e; r.a_valid = v; r.range_error = re;
    return r;
  endfunction

  task automatic add_row(item_t it, bit he, date_result_t r);
    row_t rw;
    rw.it = it; rw.has_exp = he; rw.exp = r;
    table_rows.push_back(rw);
  endtask

  task automatic build_table();
    date_result_t z;
    z = '0;
    // zero offset at the first day
    add_row(mk(FUNC_SHIFT, 0, 1, 1, 0, 1, 1, 0), 1, mkr(0, 1, 1, 0, 0, 1, 1, 0));
    // one day before the first day: range error low side
    add_row(mk(FUNC_SHIFT, 0, 1, 1, 0, 1, 2, -1), 1, mkr(0, 0, 0, 0, 1, 0, 1, 1));
    // last day plus one: range error high side
    add_row(mk(FUNC_SHIFT, 9999, 12, 31, 9999, 12, 31, 1), 1,
            mkr(0, 0, 0, 0, 0, 1, 1, 1));
    add_row(mk(FUNC_SHIFT, 9999, 12, 31, 0, 1, 1, 0), 1,
            mkr(9999, 12, 31, 0, 0, 0, 1, 0));
    // leap day handling: 2000 leap, 1900 not
    add_row(mk(FUNC_SHIFT, 2000, 2, 28, 2000, 2, 28, 1), 1,
            mkr(2000, 2, 29, 0, 0, 1, 1, 0));
    add_row(mk(FUNC_SHIFT, 1900, 2, 28, 1900, 3, 1, 1), 1,
            mkr(1900, 3, 1, 0, 1, 0, 1, 0));
    add_row(mk(FUNC_SHIFT, 1900, 2, 29, 0, 1, 1, 0), 0, z);  // invalid A
    add_row(mk(FUNC_SHIFT, 2024, 3, 1, 2024, 3, 1, -1), 1,
            mkr(2024, 2, 29, 0, 0, 1, 1, 0));
    // difference extremes
    add_row(mk(FUNC_DIFF, 9999, 12, 31, 0, 1, 1, 0), 1,
            mkr(0, 0, 0, 3652424, 0, 0, 1, 0));
    add_row(mk(FUNC_DIFF, 0, 1, 1, 9999, 12, 31, 0), 1,
            mkr(0, 0, 0, -3652424, 1, 0, 1, 0));
    // offset extremes
    add_row(mk(FUNC_SHIFT, 5000, 6, 15, 0, 1, 1, 8388607), 1,
            mkr(0, 0, 0, 0, 0, 0, 1, 1));
    add_row(mk(FUNC_SHIFT, 5000, 6, 15, 0, 1, 1, -8388608), 1,
            mkr(0, 0, 0, 0, 0, 0, 1, 1));
    add_row(mk(FUNC_SHIFT, 0, 1, 1, 0, 1, 1, 3652424), 1,
            mkr(9999, 12, 31, 0, 0, 1, 1, 0));
    // illegal months clamp, day zero and day past month end
    add_row(mk(FUNC_SHIFT, 2001, 0, 10, 2001, 1, 10, 0), 0, z);
    add_row(mk(FUNC_SHIFT, 2001, 15, 10, 2001, 12, 10, 0), 0, z);
    add_row(mk(FUNC_SHIFT, 2001, 3, 0, 0, 1, 1, 0), 0, z);
    add_row(mk(FUNC_SHIFT, 2001, 4, 31, 0, 1, 1, 0), 0, z);
    add_row(mk(FUNC_DIFF, 16383, 15, 31, 16383, 15, 31, 0), 0, z);
    add_row(mk(FUNC_DIFF, 2023, 12, 31, 2024, 1, 1, 0), 1,
            mkr(0, 0, 0, -1, 1, 0, 1, 0));
    add_row(mk(FUNC_DIFF, 2024, 5, 1, 2024, 4, 30, 0), 0, z);
    add_row(mk(FUNC_SHIFT, 1999, 12, 31, 1999, 12, 30, 366), 0, z);
  endtask

  // random item: mostly legal dates, some with illegal fields or wide years
  function automatic item_t rand_item();
    item_t it;
    int sel;
    it.func = 1'($urandom_range(0, 1));
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      it.year_a = 14'($urandom); it.year_b = 14'($urandom);
      it.month_a = 4'($urandom); it.month_b = 4'($urandom);
      it.day_a = 5'($urandom); it.day_b = 5'($urandom);
    end else begin
      it.year_a = 14'($urandom_range(0, 9999));
      it.year_b = (sel == 1) ? it.year_a : 14'($urandom_range(0, 9999));
      it.month_a = 4'($urandom_range(1, 12));
      it.month_b = (sel == 1) ? it.month_a : 4'($urandom_range(1, 12));
      it.day_a = 5'($urandom_range(1, mlen(it.year_a, it.month_a)));
      it.day_b = 5'($urandom_range(1, mlen(it.year_b, it.month_b)));
    end
    case ($urandom_range(0, 3))
      0:       it.offset = 24'($urandom);
      1:       it.offset = 24'(int'($urandom_range(0, 800)) - 400);
      default: it.offset = 24'(int'($urandom_range(0, 2000000)) - 1000000);
    endcase
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of beats with gaps, inputs change at the falling edge
  // ---------------------------------------------------------------------------
  task automatic send_item(item_t it);
    item.valid <= 1'b1;
    item.func <= it.func;
    item.year_a <= it.year_a; item.month_a <= it.month_a; item.day_a <= it.day_a;
    item.year_b <= it.year_b; item.month_b <= it.month_b; item.day_b <= it.day_b;
    item.offset <= it.offset;
    do @(posedge clk); while (!item.ready);
    @(negedge clk);
  endtask

  int burst_left;

  task automatic maybe_gap();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      item.valid <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(20, 60);
    end
  endtask

  initial begin
    item.valid = 1'b0;
    item.func = 1'b0;
    item.year_a = '0; item.month_a = '0; item.day_a = '0;
    item.year_b = '0; item.month_b = '0; item.day_b = '0;
    item.offset = '0;
    stimulus_done = 1'b0;
    burst_left = 0;
    build_table();
    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (table_rows[i]) begin
      maybe_gap();
      send_item(table_rows[i].it);
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      maybe_gap();
      send_item(rand_item());
    end
    item.valid <= 1'b0;
    stimulus_done = 1'b1;
  end

  // Expectation is queued at the accepting edge; directed rows with a
  // hand-read result are also cross-checked against the model here.
  int row_idx = 0;
  always @(posedge clk) begin
    item_t acc;
    date_result_t p;
    if (!rst && item.valid && item.ready) begin
      acc.func = item.func;
      acc.year_a = item.year_a; acc.month_a = item.month_a; acc.day_a = item.day_a;
      acc.year_b = item.year_b; acc.month_b = item.month_b; acc.day_b = item.day_b;
      acc.offset = item.offset;
      p = predict_date(acc);
      if (row_idx < table_rows.size()) begin
        if (table_rows[row_idx].has_exp) begin
          if (p !== table_rows[row_idx].exp) begin
            $error("directed row %0d: typed result disagrees with the model", row_idx);
            failures++;
          end
          p = table_rows[row_idx].exp;
        end
        row_idx++;
      end
      expected_dates.push_back(p);
      accepted_items++;
      if (acc.func == FUNC_SHIFT) shift_count++; else diff_count++;
      if (p.range_error) rerr_count++;
      if (!p.a_valid) invalid_count++;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: own stall pattern, plus one long hold-off to back up the pipe
  // ---------------------------------------------------------------------------
  initial begin
    hold_off = 1'b0;
    wait (accepted_items >= 60);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (80) @(negedge clk);
    hold_off = 1'b0;
  end

  initial begin
    int phase;
    result.ready = 1'b0;
    phase = 0;
    forever begin
      @(negedge clk);
      phase = (phase + 1) % 23;
      if (hold_off) result.ready <= 1'b0;
      else if (phase < 8) result.ready <= 1'b1;  // stretch with no stalls
      else result.ready <= (phase % 3 != 0) && ($urandom_range(0, 3) != 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  task automatic cmp(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    date_result_t e;
    if (!rst && result.valid && result.ready) begin
      if (expected_dates.size() == 0) begin
        $error("result beat with no expectation pending");
        failures++;
      end else begin
        e = expected_dates.pop_front();
        cmp("res_year", e.res_year, result.res_year);
        cmp("res_month", e.res_month, result.res_month);
        cmp("res_day", e.res_day, result.res_day);
        cmp("difference", e.difference, result.difference);
        cmp("a_less", e.a_less, result.a_less);
        cmp("a_equal", e.a_equal, result.a_equal);
        cmp("a_valid", e.a_valid, result.a_valid);
        cmp("range_error", e.range_error, result.range_error);
        checked_results++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog and end of run
  // ---------------------------------------------------------------------------
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((item.valid && item.ready) || (result.valid && result.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    failures = 0;
    accepted_items = 0;
    checked_results = 0;
    shift_count = 0; diff_count = 0; rerr_count = 0; invalid_count = 0;
    fork
      begin
        wait (stimulus_done && expected_dates.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d items: %0d shifts, %0d differences, %0d range errors,",
                 accepted_items, shift_count, diff_count, rerr_count);
        $display("%0d with illegal date A; %0d results checked", invalid_count,
                 checked_results);
        if (failures == 0 && expected_dates.size() == 0) begin
          $display("simulation ok");
        end else begin
          $display("simulation failed");
        end
      end
      begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
        $display("simulation failed");
      end
    join_any
    $finish;
  end

endmodule
